// ----- hw/rtl/rce_pkg.sv -----
package rce_pkg;

  // Fixed data widths
  localparam int unsigned ValueWidth = 64;
  localparam int unsigned BcdDigits  = 20;
  localparam int unsigned BcdWidth   = BcdDigits * 4;

  // Conversion opcodes
  localparam logic [3:0] OP_DEC_BIN = 4'd0;
  localparam logic [3:0] OP_DEC_OCT = 4'd1;
  localparam logic [3:0] OP_DEC_HEX = 4'd2;
  localparam logic [3:0] OP_BIN_DEC = 4'd3;
  localparam logic [3:0] OP_BIN_OCT = 4'd4;
  localparam logic [3:0] OP_BIN_HEX = 4'd5;
  localparam logic [3:0] OP_OCT_DEC = 4'd6;
  localparam logic [3:0] OP_OCT_BIN = 4'd7;
  localparam logic [3:0] OP_OCT_HEX = 4'd8;

  // ASCII anchors
  localparam logic [6:0] ChZero = 7'h30;
  localparam logic [6:0] ChA    = 7'h41;

  typedef enum logic [1:0] {
    BASE_2  = 2'd0,
    BASE_8  = 2'd1,
    BASE_10 = 2'd2,
    BASE_16 = 2'd3
  } base_t;

  typedef struct packed {
    logic [3:0]            opcode;
    logic [ValueWidth-1:0] number;
  } in_item_t;

  typedef struct packed {
    logic [6:0] digit_char;
    logic       last_digit;
    logic       bad_digit;
  } out_item_t;

  // Map one digit value to its ASCII character
  function automatic logic [6:0] to_ascii(input logic [3:0] d);
    logic [6:0] ch;
    if (d < 4'd10) begin
      ch = ChZero + {3'b000, d};
    end else begin
      ch = ChA + {3'b000, d - 4'd10};
    end
    return ch;
  endfunction

endpackage

// ----- hw/rtl/rce_dabble_step.sv -----
module rce_dabble_step (
  input  logic [rce_pkg::BcdWidth-1:0] bcd_in,
  input  logic                         bit_in,
  output logic [rce_pkg::BcdWidth-1:0] bcd_out
);

  logic [rce_pkg::BcdWidth-1:0] adj;

  // Add three to every digit of five or more, then shift in the next bit
  always_comb begin
    for (int i = 0; i < rce_pkg::BcdDigits; i++) begin
      if (bcd_in[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_in[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd_in[i*4 +: 4];
      end
    end
    bcd_out = {adj[rce_pkg::BcdWidth-2:0], bit_in};
  end

endmodule

// ----- hw/rtl/rce_out_reg.sv -----
module rce_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  rce_pkg::out_item_t push_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rce_pkg::out_item_t out_data
);

  logic               valid_r;
  rce_pkg::out_item_t data_r;

  assign push_ready = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_data   = data_r;

  // Hold the item until taken; refill in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push_ready) begin
      valid_r <= push_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ready && push_valid) begin
      data_r <= push_data;
    end
  end

endmodule

// ----- hw/rtl/radix_conversion_engine_unit.sv -----
// Sequence: a decimal source to base 2/8/16 loads the value, skips leading zeros and
//   emits one character per cycle while the output is not stalled; a decimal target
//   adds a binary-to-BCD pass, and a binary or octal source first runs a BCD pass
//   and a digit fold.
// Throughput: one item at a time, set by the shared double-dabble step and the
//   one-character-per-cycle emit shifter; a new item waits for the last character.
// Reset: synchronous active-low rst_n clears the sequencer, the working value and
//   output valid.
module radix_conversion_engine_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rce_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rce_pkg::out_item_t out_data
);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_DAB_SRC = 7'b0000010,
    ST_HORNER  = 7'b0000100,
    ST_DAB_DST = 7'b0001000,
    ST_SKIP    = 7'b0010000,
    ST_EMIT    = 7'b0100000,
    ST_ERR     = 7'b1000000
  } state_t;

  localparam int unsigned VW = rce_pkg::ValueWidth;
  localparam int unsigned BW = rce_pkg::BcdWidth;

  state_t                state_r, state_nxt;
  logic [6:0]            cnt_r, cnt_nxt;
  logic [VW-1:0]         work_r, work_nxt;
  logic [BW-1:0]         bcd_r, bcd_nxt;
  rce_pkg::base_t        src_r, src_nxt, dst_r, dst_nxt;
  logic                  bad_r, bad_nxt;

  rce_pkg::base_t        dec_src, dec_dst;
  logic                  dec_ok;
  logic [BW-1:0]         dab_out;
  logic [3:0]            top_digit;
  logic [3:0]            fold_digit;
  logic [VW-1:0]         fold_value;
  logic                  fold_bad;
  logic                  push_valid, push_ready;
  rce_pkg::out_item_t    push_data;

  // Left-align a value so the leading digit sits at the top of the emit register
  function automatic logic [BW-1:0] fmt_load(input rce_pkg::base_t b,
                                             input logic [VW-1:0] v);
    logic [BW-1:0] r;
    unique case (b)
      rce_pkg::BASE_8: r = {2'b00, v, {(BW-VW-2){1'b0}}};
      default:         r = {v, {(BW-VW){1'b0}}};
    endcase
    return r;
  endfunction

  // Digit slots for a value in a power-of-two base
  function automatic logic [6:0] fmt_count(input rce_pkg::base_t b);
    logic [6:0] c;
    unique case (b)
      rce_pkg::BASE_2: c = 7'(VW);
      rce_pkg::BASE_8: c = 7'((VW + 2) / 3);
      default:         c = 7'(VW / 4);
    endcase
    return c;
  endfunction

  function automatic logic [BW-1:0] shift_digit(input rce_pkg::base_t b,
                                                input logic [BW-1:0] v);
    logic [BW-1:0] r;
    unique case (b)
      rce_pkg::BASE_2: r = v << 1;
      rce_pkg::BASE_8: r = v << 3;
      default:         r = v << 4;
    endcase
    return r;
  endfunction

  // Decode the opcode into source and target bases
  always_comb begin
    dec_ok  = 1'b1;
    dec_src = rce_pkg::BASE_10;
    dec_dst = rce_pkg::BASE_2;
    unique case (in_data.opcode) inside
      rce_pkg::OP_DEC_BIN, rce_pkg::OP_DEC_OCT, rce_pkg::OP_DEC_HEX:
        dec_src = rce_pkg::BASE_10;
      rce_pkg::OP_BIN_DEC, rce_pkg::OP_BIN_OCT, rce_pkg::OP_BIN_HEX:
        dec_src = rce_pkg::BASE_2;
      rce_pkg::OP_OCT_DEC, rce_pkg::OP_OCT_BIN, rce_pkg::OP_OCT_HEX:
        dec_src = rce_pkg::BASE_8;
      default:
        dec_ok = 1'b0;
    endcase
    unique case (in_data.opcode) inside
      rce_pkg::OP_DEC_BIN, rce_pkg::OP_OCT_BIN:
        dec_dst = rce_pkg::BASE_2;
      rce_pkg::OP_DEC_OCT, rce_pkg::OP_BIN_OCT:
        dec_dst = rce_pkg::BASE_8;
      rce_pkg::OP_BIN_DEC, rce_pkg::OP_OCT_DEC:
        dec_dst = rce_pkg::BASE_10;
      default:
        dec_dst = rce_pkg::BASE_16;
    endcase
  end

  // Shared binary-to-BCD step
  rce_dabble_step u_dabble (
    .bcd_in  (bcd_r),
    .bit_in  (work_r[VW-1]),
    .bcd_out (dab_out)
  );

  // Pick the leading digit of the emit register
  always_comb begin
    unique case (dst_r)
      rce_pkg::BASE_2: top_digit = {3'b000, bcd_r[BW-1]};
      rce_pkg::BASE_8: top_digit = {1'b0, bcd_r[BW-1 -: 3]};
      default:         top_digit = bcd_r[BW-1 -: 4];
    endcase
  end

  // Fold one source digit into the value: shift by the source base and add
  always_comb begin
    fold_digit = bcd_r[BW-1 -: 4];
    if (src_r == rce_pkg::BASE_2) begin
      fold_value = (work_r << 1) + {{(VW-4){1'b0}}, fold_digit};
      fold_bad   = fold_digit > 4'd1;
    end else begin
      fold_value = (work_r << 3) + {{(VW-4){1'b0}}, fold_digit};
      fold_bad   = fold_digit > 4'd7;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    work_nxt   = work_r;
    bcd_nxt    = bcd_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;
    bad_nxt    = bad_r;
    push_valid = 1'b0;
    push_data  = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && dec_ok) begin
          src_nxt  = dec_src;
          dst_nxt  = dec_dst;
          work_nxt = in_data.number;
          bcd_nxt  = '0;
          bad_nxt  = 1'b0;
          if (dec_src != rce_pkg::BASE_10) begin
            state_nxt = ST_DAB_SRC;
            cnt_nxt   = 7'(VW - 1);
          end else if (dec_dst == rce_pkg::BASE_10) begin
            state_nxt = ST_DAB_DST;
            cnt_nxt   = 7'(VW - 1);
          end else begin
            bcd_nxt   = fmt_load(dec_dst, in_data.number);
            cnt_nxt   = fmt_count(dec_dst);
            state_nxt = ST_SKIP;
          end
        end
      end
      ST_DAB_SRC: begin
        bcd_nxt  = dab_out;
        work_nxt = work_r << 1;
        cnt_nxt  = cnt_r - 7'd1;
        if (cnt_r == 7'd0) begin
          state_nxt = ST_HORNER;
          cnt_nxt   = 7'(rce_pkg::BcdDigits - 1);
        end
      end
      ST_HORNER: begin
        work_nxt = fold_value;
        bcd_nxt  = bcd_r << 4;
        bad_nxt  = bad_r | fold_bad;
        cnt_nxt  = cnt_r - 7'd1;
        if (cnt_r == 7'd0) begin
          if (bad_r || fold_bad) begin
            state_nxt = ST_ERR;
          end else if (dst_r == rce_pkg::BASE_10) begin
            state_nxt = ST_DAB_DST;
            cnt_nxt   = 7'(VW - 1);
          end else begin
            bcd_nxt   = fmt_load(dst_r, fold_value);
            cnt_nxt   = fmt_count(dst_r);
            state_nxt = ST_SKIP;
          end
        end
      end
      ST_DAB_DST: begin
        bcd_nxt  = dab_out;
        work_nxt = work_r << 1;
        cnt_nxt  = cnt_r - 7'd1;
        if (cnt_r == 7'd0) begin
          state_nxt = ST_SKIP;
          cnt_nxt   = 7'(rce_pkg::BcdDigits);
        end
      end
      ST_SKIP: begin
        // Drop leading zeros, keeping at least one digit
        if (top_digit == 4'd0 && cnt_r > 7'd1) begin
          bcd_nxt = shift_digit(dst_r, bcd_r);
          cnt_nxt = cnt_r - 7'd1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        push_valid           = 1'b1;
        push_data.digit_char = rce_pkg::to_ascii(top_digit);
        push_data.last_digit = (cnt_r == 7'd1);
        push_data.bad_digit  = 1'b0;
        if (push_ready) begin
          bcd_nxt = shift_digit(dst_r, bcd_r);
          cnt_nxt = cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        push_valid           = 1'b1;
        push_data.digit_char = '0;
        push_data.last_digit = 1'b1;
        push_data.bad_digit  = 1'b1;
        if (push_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      bad_r   <= 1'b0;
      work_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      bad_r   <= bad_nxt;
      work_r  <= work_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bcd_r  <= bcd_nxt;
    src_r  <= src_nxt;
    dst_r  <= dst_nxt;
  end

  rce_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // An error item is always the final one
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_digit |-> out_data.last_digit)
    else $error("error item without last mark");

  // Emitting never runs with an empty digit count
  a_emit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> cnt_r != 7'd0)
    else $error("emit with zero digit count");

  // The source BCD pass consumes the whole value before the fold starts
  a_fold_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DAB_SRC && cnt_r == 7'd0 |=> work_r == '0 && state_r == ST_HORNER)
    else $error("fold started with stale value");

  // A valid opcode always starts a conversion
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && dec_ok |=> state_r != ST_IDLE)
    else $error("accepted item did not start");

endmodule
